@@ hdl/utf8_stream_validator_macros.svh @@
// Assertion macros for the UTF-8 stream validator checker.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UTF8V_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8_stream_validator: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define UTF8V_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8_stream_validator: check failed");

`endif

@@ hdl/utf8v_pkg.sv @@
// Types and constants for the UTF-8 stream validator.
package utf8v_pkg;

    localparam int unsigned CP_W = 21;

    // Number of continuation bytes that a lead byte announces
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    localparam logic [7:0] BYTE_ASCII_LIM = 8'h80;
    localparam logic [7:0] LEAD2_LO       = 8'hC2;
    localparam logic [7:0] LEAD2_HI       = 8'hDF;
    localparam logic [7:0] LEAD3_LO       = 8'hE0;
    localparam logic [7:0] LEAD3_HI       = 8'hEF;
    localparam logic [7:0] LEAD4_LO       = 8'hF0;
    localparam logic [7:0] LEAD4_HI       = 8'hF4;
    localparam logic [1:0] CONT_TAG       = 2'b10;

    localparam logic [CP_W-1:0] CP_MIN_THREE = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_FOUR  = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

    // Classified byte as handed from the front end to the decoder
    typedef struct packed {
        logic [1:0] lead_class;
        logic       lead_bad;
        logic       is_cont;
        logic [4:0] lead_bits;
        logic [5:0] cont_bits;
        logic       is_last;
    } utf8v_req_t;

endpackage

@@ hdl/utf8v_channels.sv @@
// Valid/ready channel interfaces for bytes in and verdicts out.
interface utf8v_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, data_byte, is_last, input ready);
    modport sink   (input valid, data_byte, is_last, output ready);
endinterface

interface utf8v_verdict_if;
    logic valid;
    logic ready;
    logic error_so_far;
    logic string_valid;
    logic end_of_string;

    modport source (output valid, error_so_far, string_valid, end_of_string, input ready);
    modport sink   (input valid, error_so_far, string_valid, end_of_string, output ready);
endinterface

@@ hdl/utf8v_front.sv @@
// Front end: accept bytes, classify them and register the request.
module utf8v_front
    import utf8v_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    utf8v_byte_if.sink  byte_ch,
    output logic        push_valid,
    input  logic        push_ready,
    output utf8v_req_t  push_req
);

    logic       valid_reg;
    logic       valid_next;
    utf8v_req_t req_reg;
    utf8v_req_t req_next;
    logic       take;
    logic [7:0] b;

    assign b          = byte_ch.data_byte;
    assign byte_ch.ready = !valid_reg || push_ready;
    assign take       = byte_ch.valid && byte_ch.ready;
    assign push_valid = valid_reg;
    assign push_req   = req_reg;

    always_comb
    begin
        req_next            = '0;
        req_next.is_last    = byte_ch.is_last;
        req_next.is_cont    = (b[7:6] == CONT_TAG);
        req_next.cont_bits  = b[5:0];
        if (b < BYTE_ASCII_LIM)
        begin
            req_next.lead_class = SEQ_NONE;
        end
        else if (b >= LEAD2_LO && b <= LEAD2_HI)
        begin
            req_next.lead_class = SEQ_TWO;
            req_next.lead_bits  = b[4:0];
        end
        else if (b >= LEAD3_LO && b <= LEAD3_HI)
        begin
            req_next.lead_class = SEQ_THREE;
            req_next.lead_bits  = {1'b0, b[3:0]};
        end
        else if (b >= LEAD4_LO && b <= LEAD4_HI)
        begin
            req_next.lead_class = SEQ_FOUR;
            req_next.lead_bits  = {2'b00, b[2:0]};
        end
        else
        begin
            req_next.lead_bad = 1'b1;
        end
    end

    assign valid_next = take ? 1'b1 : (push_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req_next;
        end
    end

endmodule

@@ hdl/utf8v_queue.sv @@
// Short request queue between the front end and the decoder.
module utf8v_queue
    import utf8v_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  utf8v_req_t push_req,
    output logic       pop_valid,
    input  logic       pop_ready,
    output utf8v_req_t pop_req
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    utf8v_req_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

@@ hdl/utf8v_back.sv @@
// Decoder: run the UTF-8 state update and register the verdict.
module utf8v_back
    import utf8v_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  utf8v_req_t     pop_req,
    utf8v_verdict_if.source verdict_ch
);

    logic [1:0]      pending_reg;
    logic [1:0]      pending_next;
    logic [1:0]      extra_reg;
    logic [1:0]      extra_next;
    logic [CP_W-1:0] acc_reg;
    logic [CP_W-1:0] acc_next;
    logic            err_reg;
    logic            err_next;
    logic            out_valid_reg;
    logic            out_err_reg;
    logic            out_ok_reg;
    logic            out_end_reg;
    logic            step;
    logic [1:0]      pend_d;
    logic [1:0]      extra_d;
    logic [CP_W-1:0] acc_d;
    logic            err_d;

    assign pop_ready = !out_valid_reg || verdict_ch.ready;
    assign step      = pop_valid && pop_ready;

    assign verdict_ch.valid         = out_valid_reg;
    assign verdict_ch.error_so_far  = out_err_reg;
    assign verdict_ch.string_valid  = out_ok_reg;
    assign verdict_ch.end_of_string = out_end_reg;

    always_comb
    begin
        pend_d  = pending_reg;
        extra_d = extra_reg;
        acc_d   = acc_reg;
        err_d   = err_reg;
        if (!err_reg)
        begin
            if (pending_reg == 2'd0)
            begin
                if (pop_req.lead_bad)
                begin
                    err_d = 1'b1;
                end
                else
                begin
                    unique case (pop_req.lead_class) inside
                        SEQ_NONE:
                        begin
                        end
                        SEQ_TWO, SEQ_THREE, SEQ_FOUR:
                        begin
                            acc_d   = {{(CP_W - 5){1'b0}}, pop_req.lead_bits};
                            extra_d = pop_req.lead_class;
                            pend_d  = pop_req.lead_class;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            else if (!pop_req.is_cont)
            begin
                err_d = 1'b1;
            end
            else
            begin
                acc_d  = {acc_reg[CP_W-7:0], pop_req.cont_bits};
                pend_d = pending_reg - 2'd1;
                if (pend_d == 2'd0)
                begin
                    if ((extra_reg == SEQ_THREE && acc_d < CP_MIN_THREE) ||
                        (extra_reg == SEQ_FOUR && acc_d < CP_MIN_FOUR) ||
                        (acc_d >= SURR_LO && acc_d <= SURR_HI) ||
                        (acc_d > CP_MAX))
                    begin
                        err_d = 1'b1;
                    end
                end
            end
        end
        if (pop_req.is_last && pend_d != 2'd0)
        begin
            err_d = 1'b1;
        end
    end

    always_comb
    begin
        if (pop_req.is_last)
        begin
            pending_next = 2'd0;
            extra_next   = 2'd0;
            acc_next     = '0;
            err_next     = 1'b0;
        end
        else
        begin
            pending_next = pend_d;
            extra_next   = extra_d;
            acc_next     = acc_d;
            err_next     = err_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            extra_reg     <= 2'd0;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                pending_reg <= pending_next;
                extra_reg   <= extra_next;
                acc_reg     <= acc_next;
                err_reg     <= err_next;
            end
            if (pop_ready)
            begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_err_reg <= err_d;
            out_ok_reg  <= pop_req.is_last && !err_d;
            out_end_reg <= pop_req.is_last;
        end
    end

endmodule

@@ hdl/utf8_stream_validator.sv @@
// Top level of the strict UTF-8 byte stream validator.
//
//  channel     dir  payload                                      handshake
//  byte_ch     in   data_byte[7:0], is_last                      valid/ready
//  verdict_ch  out  error_so_far, string_valid, end_of_string    valid/ready
//
// One byte per cycle sustained while verdict_ch is ready; each byte is registered in the
// front register, a queue slot and the decoder output register on its way to its verdict.
// The decoder state update is combinational and is registered on each accepted byte, so bytes follow back to back.
// Reset clears all control and decoder state; no clearing pass is needed.
// A stall on verdict_ch backs up through the queue to byte_ch.ready.
module utf8_stream_validator
    import utf8v_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    utf8v_byte_if.sink      byte_ch,
    utf8v_verdict_if.source verdict_ch
);

    logic       push_valid;
    logic       push_ready;
    utf8v_req_t push_req;
    logic       pop_valid;
    logic       pop_ready;
    utf8v_req_t pop_req;

    utf8v_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    utf8v_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    utf8v_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req),
        .verdict_ch (verdict_ch)
    );

endmodule

@@ hdl/utf8v_checker.sv @@
// Port-level checker for the UTF-8 stream validator and its bind.
`include "utf8_stream_validator_macros.svh"

module utf8v_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic error_so_far,
    input logic string_valid,
    input logic end_of_string
);

    logic       err_seen_reg;
    logic       err_seen_next;
    logic       out_take;
    logic [2:0] payload;

    assign out_take = out_valid && out_ready;
    assign payload  = {error_so_far, string_valid, end_of_string};

    always_comb
    begin
        err_seen_next = err_seen_reg;
        if (out_take)
        begin
            err_seen_next = end_of_string ? 1'b0 : (err_seen_reg || error_so_far);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg <= 1'b0;
        end
        else
        begin
            err_seen_reg <= err_seen_next;
        end
    end

    `UTF8V_ASSERT_NOW(a_valid_only_at_end, out_valid && string_valid, end_of_string)
    `UTF8V_ASSERT_NOW(a_valid_means_clean, out_valid && string_valid, !error_so_far)
    `UTF8V_ASSERT_NOW(a_error_sticks, out_valid && err_seen_reg, error_so_far)
    `UTF8V_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(payload))

endmodule

bind utf8_stream_validator utf8v_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (verdict_ch.valid),
    .out_ready     (verdict_ch.ready),
    .error_so_far  (verdict_ch.error_so_far),
    .string_valid  (verdict_ch.string_valid),
    .end_of_string (verdict_ch.end_of_string)
);
